[hdl/scpc_pkg.sv]
// ----------------------------------------------------------------------------
// scpc_pkg
// Shared types, constants and the arctangent table for the proximity checker.
// ----------------------------------------------------------------------------
package scpc_pkg;

  // q30 working word and full multiplier product
  typedef logic signed [35:0] word_t;
  typedef logic signed [71:0] prod_t;

  // angle argument in q23 degrees
  typedef logic signed [33:0] ang_t;

  localparam int MAX_CELLS = 64;
  localparam int CORDIC_STEPS = 30;

  // configuration register indexes
  localparam logic [1:0] REG_ACTIVE_CELLS = 2'd0;
  localparam logic [1:0] REG_HAZARD_RADIUS = 2'd1;
  localparam logic [1:0] REG_EARTH_RADIUS = 2'd2;

  // input beat commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic [63:0] PI180_Q39 = (PI_Q62 >> 23) / 64'd180;

  localparam ang_t DEG90 = 34'sd754974720;
  localparam ang_t DEG180 = 34'sd1509949440;
  localparam ang_t DEG360 = 34'sd3019898880;

  localparam word_t ONE_Q30 = 36'sd1073741824;

  // distance = z * r * 128000 / 463 / 2^30
  localparam logic [29:0] KM_SCALE = 30'd128000;
  localparam logic [8:0] NM_DIV = 9'd463;

  typedef word_t atan_tab_t [CORDIC_STEPS];

  // atan(2^-i) in q30, series summed in q62 and rounded
  function automatic atan_tab_t atan_table();
    atan_tab_t tab;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int sh;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        tab[i] = 36'(PI_Q62 >> 34);
      end else begin
        sum = 64'sd0;
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          sh = 62 - i * (2 * k + 1);
          term = (64'sd1 <<< sh) / 64'(2 * k + 1);
          if ((k % 2) == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        tab[i] = 36'((sum + 64'sd2147483648) >>> 32);
      end
    end
    return tab;
  endfunction

endpackage

[hdl/scpc_mul.sv]
// ----------------------------------------------------------------------------
// scpc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module scpc_mul
  import scpc_pkg::*;
(
  input  logic  clk,
  input  word_t a,
  input  word_t b,
  output prod_t p
);

  always_ff @(posedge clk) begin
    p <= prod_t'(a) * prod_t'(b);
  end

endmodule

[hdl/scpc_cdiv.sv]
// ----------------------------------------------------------------------------
// scpc_cdiv
// Unsigned divider for a 64-bit dividend by a small divisor, 8 quotient bits
// per cycle.
// ----------------------------------------------------------------------------
module scpc_cdiv
  import scpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [8:0]  den,
  output logic        busy,
  output logic [63:0] quo
);

  logic [8:0]  rem;
  logic [8:0]  den_r;
  logic [2:0]  cnt;
  logic [8:0]  rem_next;
  logic [63:0] quo_next;

  // eight restoring steps on the narrow remainder
  always_comb begin
    logic [9:0] r;
    rem_next = rem;
    quo_next = quo;
    for (int b = 0; b < 8; b++) begin
      r = {rem_next, quo_next[63]};
      quo_next = {quo_next[62:0], 1'b0};
      if (r >= {1'b0, den_r}) begin
        r = r - {1'b0, den_r};
        quo_next[0] = 1'b1;
      end
      rem_next = r[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      quo <= num;
      rem <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[hdl/storm_cell_proximity_check.sv]
// ----------------------------------------------------------------------------
// storm_cell_proximity_check
// Haversine geofence over a table of weather cells.
// ----------------------------------------------------------------------------
// A write beat (cmd 0) stores one cell and returns no result. A query beat
// (cmd 1) walks the first active_cells slots (at most 64) and returns
// one result beat: set when a thunderstorm cell lies strictly closer than
// hazard_radius (1/256 nm). in_stall stays high for the whole walk. Cells
// without the storm flag are passed over; a storm cell's distance is worked
// out by the single shared multiplier and the divider: four sines (eight
// series terms each of multiply plus divide), the haversine sum, two
// 31-step square roots, a 30-step cordic arctangent and the final scale
// and divide. The walk stops at the first hit. The result beat is held in
// an output register, so a new beat is accepted while it waits; a finished
// query waits for that register before going idle.
// ----------------------------------------------------------------------------
module storm_cell_proximity_check
  import scpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  // input beat
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [5:0]         slot,
  input  logic signed [29:0] point_lat,
  input  logic signed [30:0] point_lon,
  input  logic               storm_flag,
  // result beat
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hazard_hit
);

  typedef enum logic [4:0] {
    S_IDLE, S_CELL, S_LOAD, S_RED, S_RAD, S_X, S_X2, S_TM, S_TD, S_TMUL,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_SQ, S_CR, S_DMUL, S_DDIV, S_DWAIT, S_EMIT
  } state_t;

  localparam atan_tab_t ATAN_TAB = atan_table();

  // series divisors (2k)(2k+1)
  function automatic logic [8:0] term_div(input logic [3:0] k);
    logic [8:0] d;
    case (k)
      4'd1: d = 9'd6;
      4'd2: d = 9'd20;
      4'd3: d = 9'd42;
      4'd4: d = 9'd72;
      4'd5: d = 9'd110;
      4'd6: d = 9'd156;
      4'd7: d = 9'd210;
      default: d = 9'd272;
    endcase
    return d;
  endfunction

  state_t state;

  // configuration registers
  logic [6:0]  active_cells;
  logic [21:0] hazard_radius;
  logic [12:0] radius_km;

  // cell table
  logic signed [29:0] mem_lat [MAX_CELLS];
  logic signed [30:0] mem_lon [MAX_CELLS];
  logic               mem_storm [MAX_CELLS];
  logic signed [29:0] rd_lat;
  logic signed [30:0] rd_lon;
  logic               rd_storm;

  // query context
  logic signed [29:0] q_lat;
  logic signed [30:0] q_lon;
  logic [6:0] idx;
  logic [6:0] n_cells;
  logic       hit;

  // sine sequencer
  ang_t       ang;
  logic [1:0] sel;
  logic       rsgn;
  logic [29:0] rmag;
  word_t      t;
  word_t      s;
  word_t      x2;
  logic [3:0] k;
  logic       div_sgn;
  word_t      s1, s2, c1, c2;
  word_t      acc, tmp;

  // square root and cordic
  logic [30:0] a_reg;
  logic [61:0] sq_n;
  logic [61:0] sq_res;
  logic [4:0]  sq_j;
  logic        sq_sel;
  word_t       cx, cy, cz;
  logic [4:0]  cr_i;

  // shared units
  word_t       mul_a, mul_b;
  prod_t       p;
  logic        div_start;
  logic [63:0] div_num;
  logic [8:0]  div_den;
  logic        div_busy;
  logic [63:0] div_quo;

  scpc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  scpc_cdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // product scaled by 2^-30, truncated toward zero
  prod_t p_adj;
  word_t qm;
  assign p_adj = p + (p[71] ? 72'sd1073741823 : 72'sd0);
  assign qm = p_adj[65:30];

  // radians from the degree product, sign put back
  word_t xv;
  assign xv = rsgn ? -word_t'(p[67:32]) : word_t'(p[67:32]);

  // angle folding into [-90, 90] degrees
  ang_t r1, r2;
  always_comb begin
    r1 = ang;
    if (ang >= DEG180) begin
      r1 = ang - DEG360;
    end else if (ang < -DEG180) begin
      r1 = ang + DEG360;
    end
    r2 = r1;
    if (r1 > DEG90) begin
      r2 = DEG180 - r1;
    end else if (r1 < -DEG90) begin
      r2 = -DEG180 - r1;
    end
  end

  // next series term and partial sum
  word_t quo_w, t_new, s_fin;
  assign quo_w = word_t'(div_quo[35:0]);
  assign t_new = div_sgn ? quo_w : -quo_w;
  assign s_fin = s + t_new;

  // magnitude of the scaled product for the divider
  word_t qm_mag;
  assign qm_mag = qm[35] ? -qm : qm;

  // haversine sum clamped to [0, 1]
  word_t asum;
  logic [30:0] a_clamp;
  assign asum = acc + qm;
  always_comb begin
    if (asum[35]) begin
      a_clamp = '0;
    end else if (asum > ONE_Q30) begin
      a_clamp = 31'(ONE_Q30);
    end else begin
      a_clamp = asum[30:0];
    end
  end

  // one digit of the floor square root
  logic [61:0] sq_bit, sq_trial, sq_n_next, sq_res_next;
  always_comb begin
    sq_bit = 62'd1 << {sq_j, 1'b0};
    sq_trial = sq_res + sq_bit;
    if (sq_n >= sq_trial) begin
      sq_n_next = sq_n - sq_trial;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_n_next = sq_n;
      sq_res_next = sq_res >> 1;
    end
  end

  // one cordic vectoring rotation
  word_t cx_next, cy_next, cz_next, shx, shy;
  always_comb begin
    shx = cx >>> cr_i;
    shy = cy >>> cr_i;
    if (cy > 0) begin
      cx_next = cx + shy;
      cy_next = cy - shx;
      cz_next = cz + ATAN_TAB[cr_i];
    end else begin
      cx_next = cx - shy;
      cy_next = cy + shx;
      cz_next = cz - ATAN_TAB[cr_i];
    end
  end

  word_t z_pos;
  logic [29:0] r_scaled;
  logic [33:0] dist_nm;
  assign z_pos = cz[35] ? '0 : cz;
  assign r_scaled = 30'(radius_km) * KM_SCALE;
  assign dist_nm = div_quo[63:30];

  // shared unit operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_num = '0;
    div_den = NM_DIV;
    case (state)
      S_RAD: begin
        mul_a = word_t'({6'b0, rmag});
        mul_b = word_t'(PI180_Q39[35:0]);
      end
      S_X: begin
        mul_a = xv;
        mul_b = xv;
      end
      S_X2: begin
        mul_a = t;
        mul_b = qm;
      end
      S_TM: begin
        div_start = 1'b1;
        div_num = {28'b0, qm_mag};
        div_den = term_div(k);
      end
      S_TMUL: begin
        mul_a = t;
        mul_b = x2;
      end
      S_A0: begin
        mul_a = s1;
        mul_b = s1;
      end
      S_A1: begin
        mul_a = c1;
        mul_b = c2;
      end
      S_A2: begin
        mul_a = s2;
        mul_b = s2;
      end
      S_A3: begin
        mul_a = tmp;
        mul_b = qm;
      end
      S_DMUL: begin
        mul_a = z_pos;
        mul_b = word_t'({6'b0, r_scaled});
      end
      S_DDIV: begin
        div_start = 1'b1;
        div_num = p[63:0];
        div_den = NM_DIV;
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // cell table: written on write beats, read every cycle at the walk index
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && cmd == CMD_WRITE) begin
      mem_lat[slot] <= point_lat;
      mem_lon[slot] <= point_lon;
      mem_storm[slot] <= storm_flag;
    end
    rd_lat <= mem_lat[idx[5:0]];
    rd_lon <= mem_lon[idx[5:0]];
    rd_storm <= mem_storm[idx[5:0]];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_cells <= 7'd0;
      hazard_radius <= 22'd12800;
      radius_km <= 13'd6371;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_ACTIVE_CELLS: active_cells <= cfg_data[6:0];
        REG_HAZARD_RADIUS: hazard_radius <= cfg_data;
        REG_EARTH_RADIUS: radius_km <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
      n_cells <= '0;
      hit <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && cmd == CMD_QUERY) begin
            q_lat <= point_lat;
            q_lon <= point_lon;
            idx <= '0;
            hit <= 1'b0;
            n_cells <= (active_cells > 7'(MAX_CELLS)) ? 7'(MAX_CELLS) : active_cells;
            state <= S_CELL;
          end
        end
        S_CELL: begin
          if (idx == n_cells) begin
            state <= S_EMIT;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!rd_storm) begin
            idx <= idx + 7'd1;
            state <= S_CELL;
          end else begin
            sel <= 2'd0;
            ang <= ang_t'(rd_lat) - ang_t'(q_lat);
            state <= S_RED;
          end
        end
        S_RED: begin
          rsgn <= r2[33];
          rmag <= r2[33] ? 30'(-r2) : r2[29:0];
          state <= S_RAD;
        end
        S_RAD: state <= S_X;
        S_X: begin
          t <= xv;
          s <= xv;
          state <= S_X2;
        end
        S_X2: begin
          x2 <= qm;
          k <= 4'd1;
          state <= S_TM;
        end
        S_TM: begin
          div_sgn <= qm[35];
          state <= S_TD;
        end
        S_TD: begin
          if (!div_busy) begin
            t <= t_new;
            s <= s_fin;
            if (k == 4'd8) begin
              case (sel)
                2'd0: begin
                  s1 <= s_fin;
                  ang <= ang_t'(rd_lon) - ang_t'(q_lon);
                  state <= S_RED;
                end
                2'd1: begin
                  s2 <= s_fin;
                  ang <= (ang_t'(q_lat) <<< 1) + DEG90;
                  state <= S_RED;
                end
                2'd2: begin
                  c1 <= s_fin;
                  ang <= (ang_t'(rd_lat) <<< 1) + DEG90;
                  state <= S_RED;
                end
                default: begin
                  c2 <= s_fin;
                  state <= S_A0;
                end
              endcase
              sel <= sel + 2'd1;
            end else begin
              k <= k + 4'd1;
              state <= S_TMUL;
            end
          end
        end
        S_TMUL: state <= S_TM;
        S_A0: state <= S_A1;
        S_A1: begin
          acc <= qm;
          state <= S_A2;
        end
        S_A2: begin
          tmp <= qm;
          state <= S_A3;
        end
        S_A3: state <= S_A4;
        S_A4: begin
          a_reg <= a_clamp;
          sq_n <= 62'(a_clamp) << 30;
          sq_res <= '0;
          sq_j <= 5'd30;
          sq_sel <= 1'b0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (sq_j == 5'd0) begin
            if (!sq_sel) begin
              cy <= word_t'(sq_res_next[35:0]);
              sq_n <= 62'(31'(ONE_Q30) - a_reg) << 30;
              sq_res <= '0;
              sq_j <= 5'd30;
              sq_sel <= 1'b1;
            end else begin
              cx <= word_t'(sq_res_next[35:0]);
              cz <= '0;
              cr_i <= '0;
              state <= S_CR;
            end
          end else begin
            sq_n <= sq_n_next;
            sq_res <= sq_res_next;
            sq_j <= sq_j - 5'd1;
          end
        end
        S_CR: begin
          cx <= cx_next;
          cy <= cy_next;
          cz <= cz_next;
          cr_i <= cr_i + 5'd1;
          if (cr_i == 5'(CORDIC_STEPS - 1)) begin
            state <= S_DMUL;
          end
        end
        S_DMUL: state <= S_DDIV;
        S_DDIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (!div_busy) begin
            if (dist_nm < 34'(hazard_radius)) begin
              hit <= 1'b1;
              state <= S_EMIT;
            end else begin
              idx <= idx + 7'd1;
              state <= S_CELL;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            hazard_hit <= hit;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the divider is only started when idle
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // the walk never passes the examined cell count
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (idx <= n_cells))
    else $error("cell index beyond active count");

  // a hit needs at least one examined cell
  a_hit_cells: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && hit) |-> (n_cells != 7'd0))
    else $error("hit reported with no cells");

endmodule

[tb/storm_cell_proximity_check_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// storm_cell_proximity_check_tb
// Self-checking bench for the haversine storm cell geofence.
// ----------------------------------------------------------------------------
// Cell writes and point queries are driven through the valid/stall input
// channel. A scoreboard object keeps its own cell table and register copy,
// computes the fixed-point haversine distance of every query and checks each
// result beat in order. The run steps through several register settings,
// including the extremes, with random idling on both sides and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module storm_cell_proximity_check_tb;
  import scpc_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int NUM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 22;

  // q23 degree constants and q30 one, as 64-bit working values
  localparam longint D90 = longint'(90) <<< 23;
  localparam longint D180 = longint'(180) <<< 23;
  localparam longint D360 = longint'(360) <<< 23;
  localparam longint Q30 = longint'(1) <<< 30;
  localparam longint DEG_Q22 = longint'(1) <<< 22;

  // geofence predictor and queue of expected hit flags
  class hazard_scoreboard;
    longint cell_lat_q[MAX_CELLS];
    longint cell_lon_q[MAX_CELLS];
    bit cell_is_storm[MAX_CELLS];
    bit cell_written[MAX_CELLS];
    longint unsigned active_cnt;
    longint unsigned radius_256nm;
    longint unsigned earth_km;
    longint atan_q30[CORDIC_STEPS];
    bit expected_hits[$];
    int mismatches;

    function new();
      longint sum;
      longint term;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (i == 0) begin
          atan_q30[i] = longint'(PI_Q62 >> 34);
        end else begin
          sum = 0;
          for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = longint'((64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1));
            sum = (k % 2 == 1) ? sum - term : sum + term;
          end
          atan_q30[i] = (sum + (longint'(1) <<< 31)) >>> 32;
        end
      end
      for (int i = 0; i < MAX_CELLS; i++) begin
        cell_written[i] = 0;
      end
      active_cnt = 0;
      radius_256nm = 12800;
      earth_km = 6371;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [21:0] val);
      case (idx)
        REG_ACTIVE_CELLS: active_cnt = val[6:0];
        REG_HAZARD_RADIUS: radius_256nm = val;
        REG_EARTH_RADIUS: earth_km = val[12:0];
        default: ;
      endcase
    endfunction

    function longint mul_q30(longint p, longint q);
      return (p * q) / Q30;
    endfunction

    // sine of a q23 degree angle, q30 result
    function longint sine_q30(longint v);
      longint r, x, x2, t, s;
      longint unsigned m;
      r = v % D360;
      if (r >= D180) r = r - D360;
      else if (r < -D180) r = r + D360;
      if (r > D90) r = D180 - r;
      else if (r < -D90) r = -D180 - r;
      m = (r < 0) ? longint'(-r) : longint'(r);
      x = longint'((m * PI180_Q39) >> 32);
      if (r < 0) x = -x;
      x2 = mul_q30(x, x);
      t = x;
      s = x;
      for (int k = 1; k <= 8; k++) begin
        t = mul_q30(t, x2) / longint'((2 * k) * (2 * k + 1));
        t = -t;
        s = s + t;
      end
      return s;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
        if (n >= res + bt) begin
          n = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function longint unsigned dist_256nm(longint lat1, longint lon1,
                                         longint lat2, longint lon2);
      longint s1, s2, c1, c2, a, y, x, z, xn, yn;
      s1 = sine_q30(lat2 - lat1);
      s2 = sine_q30(lon2 - lon1);
      c1 = sine_q30(2 * lat1 + D90);
      c2 = sine_q30(2 * lat2 + D90);
      a = mul_q30(s1, s1) + mul_q30(mul_q30(c1, c2), mul_q30(s2, s2));
      if (a < 0) a = 0;
      if (a > Q30) a = Q30;
      y = longint'(floor_sqrt(longint'(a) << 30));
      x = longint'(floor_sqrt(longint'(Q30 - a) << 30));
      // cordic vectoring, floor shifts
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (y > 0) begin
          xn = x + (y >>> i);
          yn = y - (x >>> i);
          z = z + atan_q30[i];
        end else begin
          xn = x - (y >>> i);
          yn = y + (x >>> i);
          z = z - atan_q30[i];
        end
        x = xn;
        y = yn;
      end
      if (z < 0) z = 0;
      return ((longint'(z) * earth_km * 64'd128000) / 64'd463) >> 30;
    endfunction

    // an accepted input beat: store a cell or queue the expected hit flag
    function void note_beat(logic c, logic [5:0] s, logic signed [29:0] lat,
                            logic signed [30:0] lon, logic f);
      longint unsigned n;
      bit hit;
      if (c == CMD_WRITE) begin
        cell_lat_q[s] = lat;
        cell_lon_q[s] = lon;
        cell_is_storm[s] = f;
        cell_written[s] = 1;
        return;
      end
      n = (active_cnt > MAX_CELLS) ? MAX_CELLS : active_cnt;
      hit = 0;
      for (int i = 0; i < n && !hit; i++) begin
        if (cell_is_storm[i] &&
            dist_256nm(lat, lon, cell_lat_q[i], cell_lon_q[i]) < radius_256nm)
          hit = 1;
      end
      expected_hits.push_back(hit);
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected: hit=%0b", got);
        return;
      end
      want = expected_hits.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("hazard_hit mismatch: expected %0b actual %0b", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [1:0] cfg_index = REG_ACTIVE_CELLS;
  logic [21:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_WRITE;
  logic [5:0] slot = '0;
  logic signed [29:0] point_lat = '0;
  logic signed [30:0] point_lon = '0;
  logic storm_flag = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hazard_hit;

  hazard_scoreboard sb = new();
  int results_seen = 0;
  bit sender_calm = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  storm_cell_proximity_check u_dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .slot(slot), .point_lat(point_lat), .point_lon(point_lon),
    .storm_flag(storm_flag),
    .out_valid(out_valid), .out_stall(out_stall), .hazard_hit(hazard_hit)
  );

  // watchdog: cycles with no beat moving on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random stall, one long hold-off, a calm stretch
  int hold_left = 0;
  bit held_once = 0;
  always begin
    @(negedge clk);
    if (!held_once && results_seen == 12) begin
      held_once = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (results_seen >= 40 && results_seen < 70) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < 37);
    end
    @(posedge clk);
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(hazard_hit);
      results_seen++;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [21:0] val);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wen = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // one input beat; valid stays high into the next beat unless an idle follows
  task automatic send_beat(logic c, logic [5:0] s, logic signed [29:0] lat,
                           logic signed [30:0] lon, logic f);
    while (!sender_calm && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    cmd = c;
    slot = s;
    point_lat = lat;
    point_lon = lon;
    storm_flag = f;
    do @(posedge clk); while (in_stall);
    sb.note_beat(c, s, lat, lon, f);
  endtask

  // drain all expected results, then let trailing writes settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_hits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // a cell within +-90 deg latitude and +-180 deg longitude most of the time, raw bits sometimes
  task automatic random_write(logic [5:0] s);
    logic signed [29:0] lat;
    logic signed [30:0] lon;
    if ($urandom_range(9) == 0) begin
      lat = 30'($urandom);
      lon = 31'($urandom);
    end else begin
      lat = 30'($signed($urandom_range(2 * 377487360)) - 377487360);
      lon = 31'($signed($urandom_range(2 * 754974720)) - 754974720);
    end
    send_beat(CMD_WRITE, s, lat, lon, $urandom_range(9) < 6);
  endtask

  // a query close to a live cell, or anywhere at all
  task automatic random_query();
    int n;
    int k;
    logic signed [29:0] lat;
    logic signed [30:0] lon;
    n = (sb.active_cnt > MAX_CELLS) ? MAX_CELLS : int'(sb.active_cnt);
    if (n > 0 && $urandom_range(9) < 7) begin
      k = $urandom_range(n - 1);
      lat = 30'(sb.cell_lat_q[k] + ($signed($urandom_range(32'(2 * DEG_Q22))) - DEG_Q22));
      lon = 31'(sb.cell_lon_q[k] + ($signed($urandom_range(32'(2 * DEG_Q22))) - DEG_Q22));
    end else begin
      lat = 30'($urandom);
      lon = 31'($urandom);
    end
    send_beat(CMD_QUERY, 6'($urandom), lat, lon, 1'($urandom));
  endtask

  // keep every examined slot written before a query can reach it
  task automatic random_item();
    int n;
    int gap;
    n = (sb.active_cnt > MAX_CELLS) ? MAX_CELLS : int'(sb.active_cnt);
    gap = -1;
    for (int i = n - 1; i >= 0; i--) begin
      if (!sb.cell_written[i]) gap = i;
    end
    if (gap >= 0) random_write(6'(gap));
    else if ($urandom_range(9) < 4) random_write(6'($urandom));
    else random_query();
  endtask

  logic [6:0] phase_active[NUM_PHASES] = '{7'd6, 7'd3, 7'd64, 7'd100, 7'd1};
  logic [21:0] phase_radius[NUM_PHASES] =
    '{22'd12800, 22'd0, 22'd4194303, 22'd2560000, 22'd300000};
  logic [12:0] phase_earth[NUM_PHASES] =
    '{13'd6371, 13'd6000, 13'd6500, 13'd6000, 13'd6500};

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no slots examined at reset: query must miss
    send_beat(CMD_QUERY, 6'd0, 30'sd41943040, 31'sd83886080, 1'b0);
    // storm at (10, 20) deg, plus field extremes
    send_beat(CMD_WRITE, 6'd0, 30'sd41943040, 31'sd83886080, 1'b1);
    send_beat(CMD_WRITE, 6'd1, 30'sh1FFFFFFF, 31'sh3FFFFFFF, 1'b1);
    send_beat(CMD_WRITE, 6'd2, 30'sh20000000, 31'sh40000000, 1'b1);
    send_beat(CMD_WRITE, 6'd3, 30'sd377487360, -31'sd754974720, 1'b0);
    send_beat(CMD_WRITE, 6'd63, -30'sd377487360, 31'sd754974720, 1'b1);
    wait_drained();
    write_reg(REG_ACTIVE_CELLS, 22'd4);
    // exact hit, near hit, far miss, out-of-range angles wrapping
    send_beat(CMD_QUERY, 6'd0, 30'sd41943040, 31'sd83886080, 1'b0);
    send_beat(CMD_QUERY, 6'd63, 30'sd42343040, 31'sd84286080, 1'b1);
    send_beat(CMD_QUERY, 6'd0, -30'sd41943040, -31'sd83886080, 1'b0);
    send_beat(CMD_QUERY, 6'd0, 30'sh1FFFFFFF, 31'sh3FFFFFFF, 1'b0);
    send_beat(CMD_QUERY, 6'd0, 30'sh20000000, 31'sh40000000, 1'b0);
    send_beat(CMD_QUERY, 6'd0, 30'sd0, 31'sd0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_reg(REG_ACTIVE_CELLS, 22'(phase_active[p]));
      write_reg(REG_HAZARD_RADIUS, phase_radius[p]);
      write_reg(REG_EARTH_RADIUS, 22'(phase_earth[p]));
      // the middle phase runs with no sender idling
      sender_calm = (p == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
      // long table phase: fill every slot, then query the full table
      if (p == 2) begin
        for (int i = 0; i < MAX_CELLS; i++) begin
          if (!sb.cell_written[i]) random_write(6'(i));
        end
        repeat (3) random_query();
      end
    end
    sender_calm = 0;
    wait_drained();

    if (sb.mismatches == 0 && sb.expected_hits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/scpc_pkg.sv
hdl/scpc_mul.sv
hdl/scpc_cdiv.sv
hdl/storm_cell_proximity_check.sv
tb/storm_cell_proximity_check_tb.sv
